@@ rtl/core/field_match_comb_metric_top_macros.svh @@
// ----------------------------------------------------------------------------
// Field match comb metric: assertion macros
// Concurrent check shorthands used by the top level's assertions.
// ----------------------------------------------------------------------------
`ifndef FIELD_MATCH_COMB_METRIC_TOP_MACROS_SVH
`define FIELD_MATCH_COMB_METRIC_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FMCM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FMCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/fmcm_pkg.sv @@
// ----------------------------------------------------------------------------
// Field match comb metric: package
// Shared types, constants and comb arithmetic helpers.
// ----------------------------------------------------------------------------
package fmcm_pkg;

    // Size limits and configuration
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int CFG_W          = 13;
    localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd720;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd480;

    // Register index codes (paddr bit 2)
    localparam logic REG_IDX_WIDTH  = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;

    // Field choice codes
    localparam logic [1:0] CHOICE_KEEP      = 2'd0;
    localparam logic [1:0] CHOICE_PREV_EVEN = 2'd1;
    localparam logic [1:0] CHOICE_PREV_ODD  = 2'd2;

    // Arithmetic widths
    localparam int SUM_W     = 44;
    localparam int DIFF_W    = 11;
    localparam int SQ_W      = 18;
    localparam int CSUM_W    = 20;
    localparam int RES_DEPTH = 8;

    // Input transfer
    typedef struct packed {
        logic [7:0] cur_red;
        logic [7:0] cur_green;
        logic [7:0] cur_blue;
        logic [7:0] prev_red;
        logic [7:0] prev_green;
        logic [7:0] prev_blue;
        logic       no_previous;
    } fmcm_pix_t;

    // Result transfer
    typedef struct packed {
        logic [1:0]       field_choice;
        logic [SUM_W-1:0] sum_alone;
        logic [SUM_W-1:0] sum_prev_even;
        logic [SUM_W-1:0] sum_prev_odd;
    } fmcm_res_t;

    // Pixel pair: previous frame in the upper half, red in the low byte
    typedef struct packed {
        logic [23:0] prv;
        logic [23:0] cur;
    } fmcm_px_t;

    // One line store word: two rows above and one row above
    typedef struct packed {
        fmcm_px_t two_above;
        fmcm_px_t above;
    } fmcm_line_t;

    localparam int LINE_W = $bits(fmcm_line_t);

    typedef logic [2:0][SQ_W-1:0] sq3_t;

    // above + below - 2*centre for one channel
    function automatic logic signed [DIFF_W-1:0] comb_diff(
        input logic [7:0] a,
        input logic [7:0] c,
        input logic [7:0] b
    );
        logic signed [DIFF_W-1:0] va;
        logic signed [DIFF_W-1:0] vb;
        logic signed [DIFF_W-1:0] vc2;
        va  = $signed({3'b000, a});
        vb  = $signed({3'b000, b});
        vc2 = $signed({2'b00, c, 1'b0});
        return va + vb - vc2;
    endfunction

    // Square of a difference; at most 510^2, fits 18 bits
    function automatic logic [SQ_W-1:0] square(input logic signed [DIFF_W-1:0] d);
        logic signed [2*DIFF_W-1:0] p;
        p = d * d;
        return p[SQ_W-1:0];
    endfunction

    // Per-channel squared comb terms of one column triple
    function automatic sq3_t comb_sq(
        input logic [23:0] a,
        input logic [23:0] c,
        input logic [23:0] b
    );
        sq3_t sq;
        for (int i = 0; i < 3; i++)
        begin
            sq[i] = square(comb_diff(a[8*i +: 8], c[8*i +: 8], b[8*i +: 8]));
        end
        return sq;
    endfunction

    // Channel sum of the squared terms
    function automatic logic [CSUM_W-1:0] sum3(input sq3_t sq);
        return CSUM_W'(sq[0]) + CSUM_W'(sq[1]) + CSUM_W'(sq[2]);
    endfunction

endpackage

@@ rtl/core/fmcm_ram.sv @@
// ----------------------------------------------------------------------------
// Field match comb metric: line store RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fmcm_ram #(
    parameter int WIDTH = fmcm_pkg::LINE_W,
    parameter int DEPTH = fmcm_pkg::MAX_WIDTH_DEF
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the old word on a same-address collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/fmcm_fifo.sv @@
// ----------------------------------------------------------------------------
// Field match comb metric: result queue
// Small queue that decouples the pipeline from a stalled result receiver.
// ----------------------------------------------------------------------------
module fmcm_fifo #(
    parameter int DEPTH = fmcm_pkg::RES_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fmcm_pkg::fmcm_res_t push_data,
    input  logic                pop,
    output logic                valid,
    output fmcm_pkg::fmcm_res_t data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fmcm_pkg::fmcm_res_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          pop_fire;

    assign pop_fire = pop && (count_reg != '0);

    // Pointers and fill level; the caller never pushes into a full queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CW'(push) - CW'(pop_fire);
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign valid = (count_reg != '0);
    assign data  = mem_reg[rd_ptr_reg];

endmodule

@@ rtl/core/field_match_comb_metric_top.sv @@
// ----------------------------------------------------------------------------
// Field match comb metric: top level
// Scores vertical combing of three field weaves and picks the cleanest.
// ----------------------------------------------------------------------------
// Usage:
//   pix channel (valid/ready): one current/previous pixel pair per transfer,
//   raster order, frame_width x frame_height pixels per frame.
//   res channel (valid/ready): one result after the last pixel of a frame
//   (field choice and three comb sums), nothing for the other pixels.
//   APB port: register 0 frame_width at 0x0, register 1 frame_height at 0x4.
//   A write restarts the frame; write only while the block is idle.
// Timing:
//   One pixel per cycle sustained while pix_ready is high. The line store
//   RAM is read when a pixel is taken and written back on the next cycle;
//   back-to-back hits on the same column are forwarded. res_valid rises
//   once the frame totals have left the pipeline and entered the queue.
// Reset:
//   Sizes return to 720 x 480, counters and sums clear. The line stores are
//   not cleared; every entry is written before it is read within a frame.
// Stall:
//   Results wait in an 8-entry queue; pix_ready drops only when 8 results
//   are outstanding, so a stalled receiver holds back pixels of later frames.
// ----------------------------------------------------------------------------
`include "field_match_comb_metric_top_macros.svh"

module field_match_comb_metric_top #(
    parameter int MAX_WIDTH  = fmcm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fmcm_pkg::MAX_HEIGHT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_valid,
    output logic                pix_ready,
    input  fmcm_pkg::fmcm_pix_t pix,
    output logic                res_valid,
    input  logic                res_ready,
    output fmcm_pkg::fmcm_res_t res,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int XW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int CMPW = fmcm_pkg::CFG_W + 1;
    localparam int PW   = $clog2(fmcm_pkg::RES_DEPTH + 1);
    localparam int SW   = fmcm_pkg::SUM_W;
    localparam int CSW  = fmcm_pkg::CSUM_W;

    // Per-pixel control carried down the pipeline
    typedef struct packed {
        logic row1;         // row above is scored
        logic first_above;  // row above is the top row
        logic odd1;         // row above is odd
        logic row2;         // this is the last row, scored now
        logic top_row;      // this is row zero
        logic odd2;         // this row is odd
        logic last;         // last pixel of the frame
        logic no_prev;
    } ctl_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [fmcm_pkg::CFG_W-1:0] width_cfg_reg;
    logic [fmcm_pkg::CFG_W-1:0] height_cfg_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= fmcm_pkg::WIDTH_RST;
            height_cfg_reg <= fmcm_pkg::HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                fmcm_pkg::REG_IDX_WIDTH:  width_cfg_reg  <= pwdata[fmcm_pkg::CFG_W-1:0];
                fmcm_pkg::REG_IDX_HEIGHT: height_cfg_reg <= pwdata[fmcm_pkg::CFG_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            fmcm_pkg::REG_IDX_WIDTH:  prdata = 32'(width_cfg_reg);
            fmcm_pkg::REG_IDX_HEIGHT: prdata = 32'(height_cfg_reg);
        endcase
    end

    // Clamp sizes: zero counts as one, above the maximum counts as maximum
    logic [CMPW-1:0] w_lim;
    logic [CMPW-1:0] h_lim;
    logic [WW-1:0]   w_eff;
    logic [HW-1:0]   h_eff;

    always_comb
    begin
        if (width_cfg_reg == '0)
            w_lim = CMPW'(1);
        else if (CMPW'(width_cfg_reg) > CMPW'(MAX_WIDTH))
            w_lim = CMPW'(MAX_WIDTH);
        else
            w_lim = CMPW'(width_cfg_reg);
        if (height_cfg_reg == '0)
            h_lim = CMPW'(1);
        else if (CMPW'(height_cfg_reg) > CMPW'(MAX_HEIGHT))
            h_lim = CMPW'(MAX_HEIGHT);
        else
            h_lim = CMPW'(height_cfg_reg);
        w_eff = w_lim[WW-1:0];
        h_eff = h_lim[HW-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 0: raster position, RAM read issue
    // ------------------------------------------------------------------
    logic [XW-1:0]    col_reg;
    logic [YW-1:0]    row_reg;
    logic [PW-1:0]    pending_reg;
    logic             pix_fire;
    logic             wrap;
    logic [XW-1:0]    x0;
    logic [YW-1:0]    y0;
    logic [WW-1:0]    x_inc;
    logic [HW-1:0]    y_inc;
    logic             line_end;
    logic             last_row;
    ctl_t             s0_ctl;
    fmcm_pkg::fmcm_px_t s0_px;

    assign pix_ready = (pending_reg != PW'(fmcm_pkg::RES_DEPTH));
    assign pix_fire  = pix_valid && pix_ready;

    always_comb
    begin
        wrap     = (WW'(col_reg) >= w_eff) || (HW'(row_reg) >= h_eff);
        x0       = wrap ? '0 : col_reg;
        y0       = wrap ? '0 : row_reg;
        x_inc    = WW'(x0) + 1'b1;
        y_inc    = HW'(y0) + 1'b1;
        line_end = (x_inc == w_eff);
        last_row = (y_inc == h_eff);

        s0_ctl.row1        = (y0 != '0);
        s0_ctl.first_above = (y0 == YW'(1));
        s0_ctl.odd1        = ~y0[0];
        s0_ctl.row2        = last_row;
        s0_ctl.top_row     = (y0 == '0);
        s0_ctl.odd2        = y0[0];
        s0_ctl.last        = line_end && last_row;
        s0_ctl.no_prev     = pix.no_previous;

        s0_px.cur = {pix.cur_blue, pix.cur_green, pix.cur_red};
        s0_px.prv = {pix.prev_blue, pix.prev_green, pix.prev_red};
    end

    // Raster counters; a configuration write restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            if (pix_fire)
            begin
                col_reg <= line_end ? '0 : x_inc[XW-1:0];
                row_reg <= line_end ? (last_row ? '0 : y_inc[YW-1:0]) : y0;
            end
            if (cfg_wr)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line store data, forwarding, squared comb terms, write back
    // ------------------------------------------------------------------
    logic               p1_valid_reg;
    logic [XW-1:0]      p1_addr_reg;
    fmcm_pkg::fmcm_px_t p1_cur_reg;
    ctl_t               p1_ctl_reg;
    logic               p1_fwd_reg;
    fmcm_pkg::fmcm_px_t fwd_cur_reg;
    fmcm_pkg::fmcm_px_t fwd_la_reg;

    logic [fmcm_pkg::LINE_W-1:0] ram_rdata;
    logic [fmcm_pkg::LINE_W-1:0] ram_wdata;
    fmcm_pkg::fmcm_line_t        line_rd;
    fmcm_pkg::fmcm_line_t        line_wr;
    fmcm_pkg::fmcm_px_t          la_px;
    fmcm_pkg::fmcm_px_t          lt_px;
    fmcm_pkg::fmcm_px_t          ab1;
    fmcm_pkg::fmcm_px_t          ab2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else
            p1_valid_reg <= pix_fire;
    end

    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            p1_addr_reg <= x0;
            p1_cur_reg  <= s0_px;
            p1_ctl_reg  <= s0_ctl;
            // the item in stage 1 writes this column at the same edge
            p1_fwd_reg  <= p1_valid_reg && (p1_addr_reg == x0);
        end
        if (p1_valid_reg)
        begin
            fwd_cur_reg <= p1_cur_reg;
            fwd_la_reg  <= la_px;
        end
    end

    fmcm_ram #(
        .WIDTH (fmcm_pkg::LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (p1_valid_reg),
        .waddr (p1_addr_reg),
        .wdata (ram_wdata),
        .re    (pix_fire),
        .raddr (x0),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        line_rd           = fmcm_pkg::fmcm_line_t'(ram_rdata);
        la_px             = p1_fwd_reg ? fwd_cur_reg : line_rd.above;
        lt_px             = p1_fwd_reg ? fwd_la_reg : line_rd.two_above;
        line_wr.two_above = la_px;
        line_wr.above     = p1_cur_reg;
        ram_wdata         = line_wr;
        // row above: neighbors lt/cur around la; last row: la/cur around cur
        ab1 = p1_ctl_reg.first_above ? la_px : lt_px;
        ab2 = p1_ctl_reg.top_row ? p1_cur_reg : la_px;
    end

    // Squared terms: a = current alone, x = previous neighbors, y = previous centre
    logic                 p2_valid_reg;
    ctl_t                 p2_ctl_reg;
    fmcm_pkg::sq3_t       p2_a1_reg;
    fmcm_pkg::sq3_t       p2_x1_reg;
    fmcm_pkg::sq3_t       p2_y1_reg;
    fmcm_pkg::sq3_t       p2_a2_reg;
    fmcm_pkg::sq3_t       p2_x2_reg;
    fmcm_pkg::sq3_t       p2_y2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else
            p2_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (p1_valid_reg)
        begin
            p2_ctl_reg <= p1_ctl_reg;
            p2_a1_reg  <= fmcm_pkg::comb_sq(ab1.cur, la_px.cur, p1_cur_reg.cur);
            p2_x1_reg  <= fmcm_pkg::comb_sq(ab1.prv, la_px.cur, p1_cur_reg.prv);
            p2_y1_reg  <= fmcm_pkg::comb_sq(ab1.cur, la_px.prv, p1_cur_reg.cur);
            p2_a2_reg  <= fmcm_pkg::comb_sq(ab2.cur, p1_cur_reg.cur, p1_cur_reg.cur);
            p2_x2_reg  <= fmcm_pkg::comb_sq(ab2.prv, p1_cur_reg.cur, p1_cur_reg.prv);
            p2_y2_reg  <= fmcm_pkg::comb_sq(ab2.cur, p1_cur_reg.prv, p1_cur_reg.cur);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: channel sums, weave selection, accumulation
    // ------------------------------------------------------------------
    logic [SW-1:0]  acc_z_reg;
    logic [SW-1:0]  acc_e_reg;
    logic [SW-1:0]  acc_o_reg;
    logic [SW-1:0]  acc_z_next;
    logic [SW-1:0]  acc_e_next;
    logic [SW-1:0]  acc_o_next;
    logic [CSW-1:0] sx1;
    logic [CSW-1:0] sy1;
    logic [CSW-1:0] sx2;
    logic [CSW-1:0] sy2;
    logic [CSW-1:0] z1;
    logic [CSW-1:0] e1;
    logic [CSW-1:0] o1;
    logic [CSW-1:0] z2;
    logic [CSW-1:0] e2;
    logic [CSW-1:0] o2;

    always_comb
    begin
        sx1 = fmcm_pkg::sum3(p2_x1_reg);
        sy1 = fmcm_pkg::sum3(p2_y1_reg);
        sx2 = fmcm_pkg::sum3(p2_x2_reg);
        sy2 = fmcm_pkg::sum3(p2_y2_reg);
        // odd row: even weave takes previous neighbors, odd weave previous centre
        z1 = p2_ctl_reg.row1 ? fmcm_pkg::sum3(p2_a1_reg) : '0;
        e1 = p2_ctl_reg.row1 ? (p2_ctl_reg.odd1 ? sx1 : sy1) : '0;
        o1 = p2_ctl_reg.row1 ? (p2_ctl_reg.odd1 ? sy1 : sx1) : '0;
        z2 = p2_ctl_reg.row2 ? fmcm_pkg::sum3(p2_a2_reg) : '0;
        e2 = p2_ctl_reg.row2 ? (p2_ctl_reg.odd2 ? sx2 : sy2) : '0;
        o2 = p2_ctl_reg.row2 ? (p2_ctl_reg.odd2 ? sy2 : sx2) : '0;
        acc_z_next = acc_z_reg + SW'(z1) + SW'(z2);
        acc_e_next = acc_e_reg + SW'(e1) + SW'(e2);
        acc_o_next = acc_o_reg + SW'(o1) + SW'(o2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_z_reg <= '0;
            acc_e_reg <= '0;
            acc_o_reg <= '0;
        end
        else
        begin
            if (p2_valid_reg)
            begin
                acc_z_reg <= p2_ctl_reg.last ? '0 : acc_z_next;
                acc_e_reg <= p2_ctl_reg.last ? '0 : acc_e_next;
                acc_o_reg <= p2_ctl_reg.last ? '0 : acc_o_next;
            end
            if (cfg_wr)
            begin
                acc_z_reg <= '0;
                acc_e_reg <= '0;
                acc_o_reg <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: frame totals, field choice, result queue
    // ------------------------------------------------------------------
    logic                p3_valid_reg;
    logic                p3_no_prev_reg;
    logic [SW-1:0]       p3_z_reg;
    logic [SW-1:0]       p3_e_reg;
    logic [SW-1:0]       p3_o_reg;
    fmcm_pkg::fmcm_res_t res_push;
    logic                res_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_valid_reg <= 1'b0;
        else
            p3_valid_reg <= p2_valid_reg && p2_ctl_reg.last;
    end

    always_ff @(posedge clk)
    begin
        if (p2_valid_reg && p2_ctl_reg.last)
        begin
            p3_no_prev_reg <= p2_ctl_reg.no_prev;
            p3_z_reg       <= acc_z_next;
            p3_e_reg       <= acc_e_next;
            p3_o_reg       <= acc_o_next;
        end
    end

    always_comb
    begin
        res_push.sum_alone     = p3_z_reg;
        res_push.sum_prev_even = p3_e_reg;
        res_push.sum_prev_odd  = p3_o_reg;
        priority if (p3_no_prev_reg)
        begin
            res_push.field_choice  = fmcm_pkg::CHOICE_KEEP;
            res_push.sum_alone     = '0;
            res_push.sum_prev_even = '0;
            res_push.sum_prev_odd  = '0;
        end
        else if (p3_z_reg < p3_e_reg)
            res_push.field_choice = (p3_o_reg < p3_z_reg) ? fmcm_pkg::CHOICE_PREV_ODD
                                                          : fmcm_pkg::CHOICE_KEEP;
        else
            res_push.field_choice = (p3_o_reg < p3_e_reg) ? fmcm_pkg::CHOICE_PREV_ODD
                                                          : fmcm_pkg::CHOICE_PREV_EVEN;
    end

    fmcm_fifo #(
        .DEPTH (fmcm_pkg::RES_DEPTH)
    ) u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (p3_valid_reg),
        .push_data (res_push),
        .pop       (res_ready),
        .valid     (res_valid),
        .data      (res)
    );

    // Results outstanding from frame-end pixel taken until result transfer
    assign res_pop = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_reg + PW'(pix_fire && s0_ctl.last) - PW'(res_pop);
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `FMCM_ASSERT_SAME(a_res_pending, res_valid, pending_reg != '0,
        "result queued without an outstanding frame")
    `FMCM_ASSERT_NEXT(a_last_flows, pix_fire && s0_ctl.last, p1_valid_reg && p1_ctl_reg.last,
        "frame-end pixel lost entering the pipeline")
    `FMCM_ASSERT_NEXT(a_cfg_restart, cfg_wr,
        col_reg == '0 && row_reg == '0 && acc_z_reg == '0 && acc_o_reg == '0,
        "configuration write did not restart the frame")

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Field match comb metric: block-level testbench
// Streams current/previous pixel pairs through the block at many frame sizes
// and fill patterns, predicts the per-frame field choice and comb sums in a
// cycle-free model, and checks every result transfer against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RANDOM_ITEMS  = 930;
    localparam int MIN_FRAMES    = 48;
    localparam int BIG_PART      = 48;
    localparam int SUM_W         = fmcm_pkg::SUM_W;
    localparam int CFG_W         = fmcm_pkg::CFG_W;
    localparam int MAX_W         = fmcm_pkg::MAX_WIDTH_DEF;
    localparam int MAX_H         = fmcm_pkg::MAX_HEIGHT_DEF;

    // Content patterns for one frame
    typedef enum int {
        FILL_RANDOM,
        FILL_KEEP,
        FILL_EVEN,
        FILL_ODD,
        FILL_SAME,
        FILL_EXTREME,
        FILL_STRIPES,
        FILL_SATURATED
    } fill_e;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                pix_valid = 1'b0;
    logic                pix_ready;
    fmcm_pkg::fmcm_pix_t pix       = '0;
    logic                res_valid;
    logic                res_ready = 1'b0;
    fmcm_pkg::fmcm_res_t res;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [2:0]          paddr     = '0;
    logic [31:0]         pwdata    = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Pixel transfers waiting to be driven, results waiting to be seen
    fmcm_pkg::fmcm_pix_t pixel_q[$];
    fmcm_pkg::fmcm_res_t frame_result_q[$];

    int pixels_queued  = 0;
    int pixels_taken   = 0;
    int frames_checked = 0;
    int mismatch_count = 0;
    int size_settings  = 0;
    int largest_area   = 0;
    int cycle_count    = 0;

    // Sender and receiver pacing
    int                  burst_left = 0;
    int                  gap_left   = 0;
    bit                  launch;
    int                  stall_left = 0;
    bit                  ready_next;
    int                  roll;
    fmcm_pkg::fmcm_res_t want_res;

    // Predictor state
    bit [47:0]        line_above_mem [MAX_W];
    bit [47:0]        line_two_mem   [MAX_W];
    bit [CFG_W-1:0]   cfg_width  = fmcm_pkg::WIDTH_RST;
    bit [CFG_W-1:0]   cfg_height = fmcm_pkg::HEIGHT_RST;
    int unsigned      col_idx    = 0;
    int unsigned      row_idx    = 0;
    bit [SUM_W-1:0]   energy_alone = '0;
    bit [SUM_W-1:0]   energy_even  = '0;
    bit [SUM_W-1:0]   energy_odd   = '0;

    field_match_comb_metric_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Clock: 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Zero counts as one, anything past the store depth as the maximum
    function automatic int eff_size(input bit [CFG_W-1:0] raw, input int maxv);
        if (raw == 0)
            return 1;
        return (raw > maxv) ? maxv : int'(raw);
    endfunction

    // Squared vertical second difference, summed over the three channels
    function automatic longint unsigned comb_energy(
        input bit [23:0] a,
        input bit [23:0] c,
        input bit [23:0] b
    );
        longint unsigned acc;
        int d;
        acc = 0;
        for (int i = 0; i < 3; i++)
        begin
            d = int'(a[8*i +: 8]) + int'(b[8*i +: 8]) - 2 * int'(c[8*i +: 8]);
            acc += longint'(d * d);
        end
        return acc;
    endfunction

    // Score one row into the three weaves; low half is current, high half previous
    function automatic void accumulate_row(
        input bit [47:0] ab,
        input bit [47:0] ce,
        input bit [47:0] be,
        input bit        odd_row
    );
        energy_alone += SUM_W'(comb_energy(ab[23:0], ce[23:0], be[23:0]));
        if (odd_row)
        begin
            energy_even += SUM_W'(comb_energy(ab[47:24], ce[23:0], be[47:24]));
            energy_odd  += SUM_W'(comb_energy(ab[23:0], ce[47:24], be[23:0]));
        end
        else
        begin
            energy_even += SUM_W'(comb_energy(ab[23:0], ce[47:24], be[23:0]));
            energy_odd  += SUM_W'(comb_energy(ab[47:24], ce[23:0], be[47:24]));
        end
    endfunction

    // Advance the frame by one accepted pixel pair; queue a result at frame end
    function automatic void predict_pixel(input fmcm_pkg::fmcm_pix_t p);
        bit [47:0]           cur;
        bit [47:0]           above;
        bit [47:0]           two_above;
        int unsigned         w;
        int unsigned         h;
        int unsigned         x;
        int unsigned         r;
        fmcm_pkg::fmcm_res_t want;
        cur = {p.prev_blue, p.prev_green, p.prev_red, p.cur_blue, p.cur_green, p.cur_red};
        w = eff_size(cfg_width, MAX_W);
        h = eff_size(cfg_height, MAX_H);
        x = col_idx;
        r = row_idx;
        if (x >= w || r >= h)
        begin
            x = 0;
            r = 0;
        end
        above     = line_above_mem[x];
        two_above = line_two_mem[x];

        // Row above is scored now; the last row also scores itself, clamped below
        if (r >= 1)
            accumulate_row((r == 1) ? above : two_above, above, cur, (r - 1) % 2 == 1);
        if (r == h - 1)
            accumulate_row((r == 0) ? cur : above, cur, cur, r % 2 == 1);

        line_two_mem[x]   = above;
        line_above_mem[x] = cur;

        if (x + 1 < w)
        begin
            col_idx = x + 1;
            row_idx = r;
        end
        else if (r + 1 < h)
        begin
            col_idx = 0;
            row_idx = r + 1;
        end
        else
        begin
            want = '0;
            want.field_choice = fmcm_pkg::CHOICE_KEEP;
            if (!p.no_previous)
            begin
                if (energy_alone < energy_even)
                    want.field_choice = (energy_odd < energy_alone) ? fmcm_pkg::CHOICE_PREV_ODD
                                                                    : fmcm_pkg::CHOICE_KEEP;
                else
                    want.field_choice = (energy_odd < energy_even) ? fmcm_pkg::CHOICE_PREV_ODD
                                                                   : fmcm_pkg::CHOICE_PREV_EVEN;
                want.sum_alone     = energy_alone;
                want.sum_prev_even = energy_even;
                want.sum_prev_odd  = energy_odd;
            end
            frame_result_q.push_back(want);
            col_idx      = 0;
            row_idx      = 0;
            energy_alone = '0;
            energy_even  = '0;
            energy_odd   = '0;
        end
    endfunction

    task automatic compare_value(
        input string            what,
        input logic [SUM_W-1:0] want,
        input logic [SUM_W-1:0] got
    );
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // One pixel pair with the given content pattern
    function automatic fmcm_pkg::fmcm_pix_t make_pixel(
        input fill_e    fill,
        input int       row,
        input int       col,
        input bit [7:0] base
    );
        bit [63:0]           rnd;
        bit [7:0]            s;
        bit [23:0]           ramp;
        fmcm_pkg::fmcm_pix_t p;
        rnd  = {$urandom(), $urandom()};
        p    = rnd[$bits(fmcm_pkg::fmcm_pix_t)-1:0];
        s    = 8'(base + 4 * row + col);
        ramp = {~s, s + 8'd16, s};
        case (fill)
            FILL_KEEP:
                {p.cur_blue, p.cur_green, p.cur_red} = ramp;
            FILL_EVEN:
                if (row % 2 == 0)
                    {p.prev_blue, p.prev_green, p.prev_red} = ramp;
                else
                    {p.cur_blue, p.cur_green, p.cur_red} = ramp;
            FILL_ODD:
                if (row % 2 == 0)
                    {p.cur_blue, p.cur_green, p.cur_red} = ramp;
                else
                    {p.prev_blue, p.prev_green, p.prev_red} = ramp;
            FILL_SAME:
                {p.prev_blue, p.prev_green, p.prev_red} = {p.cur_blue, p.cur_green, p.cur_red};
            FILL_EXTREME:
            begin
                p.cur_red    = {8{rnd[49]}};
                p.cur_green  = {8{rnd[50]}};
                p.cur_blue   = {8{rnd[51]}};
                p.prev_red   = {8{rnd[52]}};
                p.prev_green = {8{rnd[53]}};
                p.prev_blue  = {8{rnd[54]}};
            end
            FILL_STRIPES:
            begin
                {p.cur_blue, p.cur_green, p.cur_red} = (row % 2 == 1) ? 24'hFFFFFF : 24'h0;
                {p.prev_blue, p.prev_green, p.prev_red} = ~{p.cur_blue, p.cur_green, p.cur_red};
            end
            FILL_SATURATED:
            begin
                {p.cur_blue, p.cur_green, p.cur_red}    = 24'hFFFFFF;
                {p.prev_blue, p.prev_green, p.prev_red} = 24'h0;
            end
            default: ;
        endcase
        return p;
    endfunction

    // Queue a whole frame, or only its first part pixels when part is nonzero
    task automatic queue_frame(input fill_e fill, input bit np_last, input int part);
        int                  w;
        int                  h;
        int                  count;
        bit [7:0]            base;
        fmcm_pkg::fmcm_pix_t p;
        w     = eff_size(cfg_width, MAX_W);
        h     = eff_size(cfg_height, MAX_H);
        count = (part > 0) ? part : w * h;
        base  = 8'($urandom());
        @(negedge clk);
        for (int i = 0; i < count; i++)
        begin
            p = make_pixel(fill, i / w, i % w, base);
            // only the last pixel's flag matters; the rest mostly follow it
            p.no_previous = (i == w * h - 1 || $urandom_range(0, 7) != 0) ? np_last
                                                                          : ~np_last;
            pixel_q.push_back(p);
        end
        pixels_queued += count;
    endtask

    // All queued pixels taken, all results seen, pipeline drained
    task automatic wait_idle();
        while (pixels_taken != pixels_queued)
            @(posedge clk);
        while (frame_result_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, access cycle; the access completes on pready
    task automatic apb_access(
        input  logic        reg_idx,
        input  bit          is_write,
        input  logic [31:0] wdata,
        output logic [31:0] rdata
    );
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Program frame size once idle; any write restarts the frame
    task automatic program_size(
        input bit [CFG_W-1:0] raw_w,
        input bit [CFG_W-1:0] raw_h,
        input bit             do_w,
        input bit             do_h
    );
        logic [31:0] rd;
        wait_idle();
        if (do_w)
        begin
            apb_access(fmcm_pkg::REG_IDX_WIDTH, 1'b1, ($urandom() & ~32'h1FFF) | raw_w, rd);
            cfg_width = raw_w;
        end
        if (do_h)
        begin
            apb_access(fmcm_pkg::REG_IDX_HEIGHT, 1'b1, ($urandom() & ~32'h1FFF) | raw_h, rd);
            cfg_height = raw_h;
        end
        col_idx      = 0;
        row_idx      = 0;
        energy_alone = '0;
        energy_even  = '0;
        energy_odd   = '0;
        apb_access(fmcm_pkg::REG_IDX_WIDTH, 1'b0, $urandom(), rd);
        compare_value("frame_width readback", SUM_W'(cfg_width), SUM_W'(rd[CFG_W-1:0]));
        apb_access(fmcm_pkg::REG_IDX_HEIGHT, 1'b0, $urandom(), rd);
        compare_value("frame_height readback", SUM_W'(cfg_height), SUM_W'(rd[CFG_W-1:0]));
        size_settings++;
        if (eff_size(cfg_width, MAX_W) * eff_size(cfg_height, MAX_H) > largest_area)
            largest_area = eff_size(cfg_width, MAX_W) * eff_size(cfg_height, MAX_H);
    endtask

    // Mostly small sizes, some zeros, a few medium ones
    function automatic bit [CFG_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 18)
            return CFG_W'($urandom_range(9, 24));
        return CFG_W'($urandom_range(1, 8));
    endfunction

    // Pixel driver: bursts of transfers with random gaps between them
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pix_valid <= 1'b0;
        end
        else
        begin
            if (pix_valid && pix_ready)
            begin
                predict_pixel(pix);
                pixels_taken <= pixels_taken + 1;
            end
            if (!pix_valid || pix_ready)
            begin
                launch = 1'b0;
                if (gap_left > 0)
                    gap_left = gap_left - 1;
                else if (pixel_q.size() != 0)
                begin
                    launch = 1'b1;
                    pix <= pixel_q.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left = burst_left - 1;
                end
                pix_valid <= launch;
            end
        end
    end

    // Result monitor and receiver stall pattern
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (frame_result_q.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %0d %0d %0d %0d",
                             $time, res.field_choice, res.sum_alone, res.sum_prev_even,
                             res.sum_prev_odd);
                    mismatch_count++;
                end
                else
                begin
                    want_res = frame_result_q.pop_front();
                    compare_value("field_choice", SUM_W'(want_res.field_choice),
                                  SUM_W'(res.field_choice));
                    compare_value("sum_alone", want_res.sum_alone, res.sum_alone);
                    compare_value("sum_prev_even", want_res.sum_prev_even, res.sum_prev_even);
                    compare_value("sum_prev_odd", want_res.sum_prev_odd, res.sum_prev_odd);
                    frames_checked++;
                end
            end
            // ready held high while cycle_count bits 11:9 are zero and no long stall runs, else short and long stalls
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                ready_next = 1'b0;
            end
            else if (cycle_count[11:9] == 3'd0)
                ready_next = 1'b1;
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 60)
                    ready_next = 1'b1;
                else if (roll < 90)
                    ready_next = 1'b0;
                else
                begin
                    stall_left = $urandom_range(4, 40);
                    ready_next = 1'b0;
                end
            end
            res_ready <= ready_next;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, frame_result_q.size());
            $display("field_match_comb_metric_top test failed");
            $finish;
        end
    end

    // Stimulus
    initial
    begin : stimulus
        logic [31:0]    rd;
        bit [CFG_W-1:0] raw_w;
        bit [CFG_W-1:0] raw_h;
        int             sel;
        int             area;
        int             random_start;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers come out of reset at their defaults
        apb_access(fmcm_pkg::REG_IDX_WIDTH, 1'b0, $urandom(), rd);
        compare_value("frame_width after reset", SUM_W'(fmcm_pkg::WIDTH_RST),
                      SUM_W'(rd[CFG_W-1:0]));
        apb_access(fmcm_pkg::REG_IDX_HEIGHT, 1'b0, $urandom(), rd);
        compare_value("frame_height after reset", SUM_W'(fmcm_pkg::HEIGHT_RST),
                      SUM_W'(rd[CFG_W-1:0]));

        // Zero sizes act as a single pixel; first-frame flag zeroes the result
        program_size('0, '0, 1'b1, 1'b1);
        queue_frame(FILL_SATURATED, 1'b0, 0);
        queue_frame(FILL_SATURATED, 1'b1, 0);

        // Full-swing stripes: worst combing, opposite phase in the previous frame
        program_size(CFG_W'(3), CFG_W'(3), 1'b1, 1'b1);
        queue_frame(FILL_STRIPES, 1'b0, 0);

        // Identical frames: all three sums tie
        program_size(CFG_W'(2), CFG_W'(2), 1'b1, 1'b1);
        queue_frame(FILL_SAME, 1'b0, 0);

        // Single column, levels at the rails
        program_size(CFG_W'(1), CFG_W'(4), 1'b1, 1'b1);
        queue_frame(FILL_EXTREME, 1'b0, 0);

        // Frame cut short, then restarted by a register write
        program_size(CFG_W'(2), CFG_W'(2), 1'b1, 1'b1);
        queue_frame(FILL_RANDOM, 1'b0, 3);

        // Largest sizes, in range and clamped, one line or one column, cut short
        program_size(CFG_W'(MAX_W), CFG_W'(1), 1'b1, 1'b1);
        queue_frame(FILL_RANDOM, 1'b0, BIG_PART);
        program_size(CFG_W'(8191), CFG_W'(1), 1'b1, 1'b0);
        queue_frame(FILL_EXTREME, 1'b0, BIG_PART);
        program_size(CFG_W'(1), CFG_W'(MAX_H), 1'b1, 1'b1);
        queue_frame(FILL_ODD, 1'b0, BIG_PART);
        program_size(CFG_W'(1), CFG_W'(8191), 1'b0, 1'b1);
        queue_frame(FILL_EVEN, 1'b0, BIG_PART);

        // Random sizes and content, now and then a frame left unfinished
        random_start = pixels_queued;
        while (pixels_queued - random_start < RANDOM_ITEMS || frames_checked < MIN_FRAMES)
        begin
            raw_w = pick_size();
            raw_h = pick_size();
            sel   = $urandom_range(0, 9);
            program_size(raw_w, raw_h, sel != 0, sel != 1);
            area = eff_size(cfg_width, MAX_W) * eff_size(cfg_height, MAX_H);
            repeat ($urandom_range(1, 3))
                queue_frame(fill_e'($urandom_range(0, int'(FILL_SATURATED))),
                            $urandom_range(0, 4) == 0, 0);
            if (area > 1 && $urandom_range(0, 5) == 0)
                queue_frame(FILL_RANDOM, $urandom_range(0, 1), $urandom_range(1, area - 1));
        end

        wait_idle();
        $display("Checked %0d frame results from %0d pixel transfers over %0d size settings,",
                 frames_checked, pixels_queued, size_settings);
        $display("largest frame %0d pixels, partial frames and clamped sizes included.",
                 largest_area);
        if (mismatch_count == 0)
            $display("field_match_comb_metric_top test passed");
        else
            $display("field_match_comb_metric_top test failed");
        $finish;
    end

endmodule

@@ field_match_comb_metric_top.f @@
+incdir+rtl/core
rtl/core/fmcm_pkg.sv
rtl/core/fmcm_ram.sv
rtl/core/fmcm_fifo.sv
rtl/core/field_match_comb_metric_top.sv
test/tb_top.sv
